// ===== rtl/core/sfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg: shared types for the slicing floorplan packer
// Beat structs, op codes, controller/datapath command and status, saturating add.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned COORD_W = 21;
  localparam int unsigned AREA_W  = 42;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  typedef enum logic [1:0] {
    OP_LEAF = 2'd0,
    OP_HCUT = 2'd1,
    OP_VCUT = 2'd2,
    OP_BAD  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  module_id;
    logic [15:0] module_width;
    logic [15:0] module_height;
    logic        final_item;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]         leaf_ident;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [AREA_W-1:0]  total_area;
    logic               invalid;
    logic               last_result;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic leaf;      // write leaf and push
    logic cut_init;  // read stack operands
    logic cut_step;  // shift one leaf
    logic cut_done;  // merge clusters
    logic err;       // flag error
    logic area;      // multiply bounding box
    logic emit;      // present leaf at emit index
    logic emit_bad;  // present flagged result
    logic clear;     // end of expression
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       err_seen;
    logic       depth_lt2;
    logic       full;
    logic       depth_one;
    logic       cut_last;
    logic       emit_last;
  } sts_t;

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/sfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_ctrl: sequencer for the floorplan packer
// Decodes items into push, cut-shift loops and the output sweep.
// ----------------------------------------------------------------------------
module sfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        op,
  input  logic              final_item,
  input  sfp_pkg::sts_t     sts,
  output sfp_pkg::cmd_t     cmd,
  output logic              busy
);
  import sfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_CUT, S_FIN, S_AREA, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r;
  op_t    op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r   <= 1'b0;
      op_r    <= OP_LEAF;
    end else begin
      state_r <= state_nxt;
      if (start && !busy) begin
        fin_r <= final_item;
        op_r  <= op_t'(op);
      end
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = fin_r ? S_FIN : S_IDLE;
        // items after an error are dropped until the final one
        if (!sts.err_seen) begin
          unique case (op_r) inside
            OP_LEAF: begin
              if (sts.full) cmd.err = 1'b1;
              else          cmd.leaf = 1'b1;
            end
            OP_HCUT, OP_VCUT: begin
              if (sts.depth_lt2) cmd.err = 1'b1;
              else begin
                cmd.cut_init = 1'b1;
                state_nxt    = S_CUT;
              end
            end
            default: cmd.err = 1'b1;
          endcase
        end
      end
      S_CUT: begin
        cmd.cut_step = 1'b1;
        if (sts.cut_last) begin
          cmd.cut_done = 1'b1;
          state_nxt    = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.err_seen || !sts.depth_one) begin
          cmd.emit_bad = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.area  = 1'b1;
          state_nxt = S_AREA;
        end
      end
      S_AREA: state_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/sfp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_dp: leaf and cluster storage with shift and emit datapath
// Stack and leaf tables in registers, one leaf coordinate updated a cycle.
// ----------------------------------------------------------------------------
module sfp_dp #(
  parameter int unsigned MAX_MODULES = 32,
  parameter int unsigned DIM_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sfp_pkg::in_beat_t   in_beat,
  input  sfp_pkg::cmd_t       cmd,
  output sfp_pkg::sts_t       sts,
  output logic                out_valid,
  output sfp_pkg::out_beat_t  out_beat
);
  import sfp_pkg::*;

  localparam int unsigned IW = $clog2(MAX_MODULES);
  localparam int unsigned CW = $clog2(MAX_MODULES + 1);

  logic [7:0]         ids_r [MAX_MODULES];
  logic [COORD_W-1:0] xs_r  [MAX_MODULES];
  logic [COORD_W-1:0] ys_r  [MAX_MODULES];
  logic [IW-1:0]      sfirst_r [MAX_MODULES];
  logic [IW-1:0]      slast_r  [MAX_MODULES];
  logic [COORD_W-1:0] sw_r  [MAX_MODULES];
  logic [COORD_W-1:0] sh_r  [MAX_MODULES];

  logic [CW-1:0] depth_r, count_r;
  logic          err_r;
  in_beat_t      item_r;

  logic [IW-1:0]      j_r, jlast_r;
  logic [COORD_W-1:0] off_r;
  logic               hor_r;
  logic [IW-1:0]      li_r, ri_r;
  logic [COORD_W-1:0] lw_r, lh_r, rw_r, rh_r;
  logic [AREA_W-1:0]  area_r;
  logic [IW-1:0]      k_r;

  logic [COORD_W-1:0] dw, dh;
  logic [IW-1:0]      top, nxt_top, cnt_i;
  assign dw      = COORD_W'(item_r.module_width  & 16'((17'd1 << DIM_BITS) - 1));
  assign dh      = COORD_W'(item_r.module_height & 16'((17'd1 << DIM_BITS) - 1));
  assign top     = IW'(depth_r - CW'(1));
  assign nxt_top = IW'(depth_r - CW'(2));
  assign cnt_i   = IW'(count_r);

  assign sts.err_seen  = err_r;
  assign sts.depth_lt2 = depth_r < CW'(2);
  assign sts.full      = (count_r >= CW'(MAX_MODULES)) || (depth_r >= CW'(MAX_MODULES));
  assign sts.depth_one = depth_r == CW'(1);
  assign sts.cut_last  = j_r == jlast_r;
  assign sts.emit_last = CW'(k_r) + CW'(1) >= count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= '0;
      count_r   <= '0;
      err_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || cmd.emit_bad;
      if (cmd.leaf) begin
        depth_r <= depth_r + CW'(1);
        count_r <= count_r + CW'(1);
      end
      if (cmd.cut_done) depth_r <= depth_r - CW'(1);
      if (cmd.err) err_r <= 1'b1;
      if (cmd.clear) begin
        depth_r <= '0;
        count_r <= '0;
        err_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_beat;
    if (cmd.leaf) begin
      ids_r[cnt_i]    <= item_r.module_id;
      xs_r[cnt_i]     <= '0;
      ys_r[cnt_i]     <= '0;
      sfirst_r[top + IW'(1)] <= cnt_i;
      slast_r[top + IW'(1)]  <= cnt_i;
      sw_r[top + IW'(1)] <= dw;
      sh_r[top + IW'(1)] <= dh;
    end
    if (cmd.cut_init) begin
      hor_r   <= item_r.op == OP_HCUT;
      li_r    <= nxt_top;
      ri_r    <= top;
      j_r     <= sfirst_r[top];
      jlast_r <= slast_r[top];
      off_r   <= (item_r.op == OP_HCUT) ? sh_r[nxt_top] : sw_r[nxt_top];
      lw_r    <= sw_r[nxt_top];
      lh_r    <= sh_r[nxt_top];
      rw_r    <= sw_r[top];
      rh_r    <= sh_r[top];
    end
    if (cmd.cut_step) begin
      if (hor_r) ys_r[j_r] <= sat_add(ys_r[j_r], off_r);
      else       xs_r[j_r] <= sat_add(xs_r[j_r], off_r);
      j_r <= j_r + IW'(1);
    end
    if (cmd.cut_done) begin
      slast_r[li_r] <= slast_r[ri_r];
      if (hor_r) begin
        sw_r[li_r] <= (lw_r > rw_r) ? lw_r : rw_r;
        sh_r[li_r] <= sat_add(lh_r, rh_r);
      end else begin
        sw_r[li_r] <= sat_add(lw_r, rw_r);
        sh_r[li_r] <= (lh_r > rh_r) ? lh_r : rh_r;
      end
    end
    if (cmd.area) begin
      area_r <= AREA_W'(sw_r[0]) * AREA_W'(sh_r[0]);
      k_r    <= '0;
    end
    if (cmd.emit) begin
      out_beat.leaf_ident  <= ids_r[k_r];
      out_beat.pos_x       <= xs_r[k_r];
      out_beat.pos_y       <= ys_r[k_r];
      out_beat.total_area  <= area_r;
      out_beat.invalid     <= 1'b0;
      out_beat.last_result <= sts.emit_last;
      k_r <= k_r + IW'(1);
    end
    if (cmd.emit_bad) out_beat <= '{8'd0, '0, '0, '0, 1'b1, 1'b1};
  end

endmodule

// ===== rtl/core/slicing_floorplan_packer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slicing_floorplan_packer_top: postfix slicing floorplan evaluator
// Places leaf modules from a Polish expression and reports coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_beat and raise start; the item is taken on an edge where busy
//   is low. A leaf item is decoded and pushed. A cut is decoded, then the
//   shift unit walks the leaves of the right cluster, updating one stored
//   coordinate per cycle, and the two clusters merge. On the final item a
//   valid expression has its area computed and then emits
//   one result beat per leaf on consecutive cycles, each marked by
//   out_valid for one cycle; the last beat has last_result set. An invalid
//   expression (underflow, capacity overflow, bad op, depth not one) gives
//   one beat with invalid set and zero payload.
//   The receiver cannot stall: every beat is taken the cycle it appears.
//   Synchronous reset clears depth, leaf count, error flag and the
//   sequencer; the leaf and cluster tables hold no reset value and are
//   always written before being read.
// ----------------------------------------------------------------------------
module slicing_floorplan_packer_top #(
  parameter int unsigned MAX_MODULES = 32,
  parameter int unsigned DIM_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sfp_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output sfp_pkg::out_beat_t out_beat
);
  import sfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op         (in_beat.op),
    .final_item (in_beat.final_item),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  sfp_dp #(
    .MAX_MODULES (MAX_MODULES),
    .DIM_BITS    (DIM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

// ===== dv/sfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_checker: scoreboard for the slicing floorplan packer
// Watches accepted input and result beats, predicts placements, compares.
// ----------------------------------------------------------------------------
module sfp_checker #(
  parameter int unsigned MAX_MODULES = 32,
  parameter int unsigned DIM_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  sfp_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  sfp_pkg::out_beat_t out_beat,
  output int                 fail_count,
  output int                 pending
);
  import sfp_pkg::*;

  localparam logic [20:0] CMAX = 21'h1FFFFF;

  logic [7:0]  lf_id [MAX_MODULES];
  logic [20:0] lf_x  [MAX_MODULES];
  logic [20:0] lf_y  [MAX_MODULES];
  int          cl_first [MAX_MODULES];
  int          cl_last  [MAX_MODULES];
  logic [20:0] cl_w [MAX_MODULES];
  logic [20:0] cl_h [MAX_MODULES];
  int          depth;
  int          nleaf;
  bit          err;
  out_beat_t   placements_q[$];

  function automatic logic [20:0] add_sat(logic [20:0] a, logic [20:0] b);
    logic [21:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[21] ? CMAX : s[20:0];
  endfunction

  function automatic logic [20:0] dim(logic [15:0] v);
    logic [15:0] m;
    m = v & ((16'h1 << DIM_BITS) - 1);
    return {5'd0, m};
  endfunction

  task automatic place_item(in_beat_t b);
    out_beat_t o;
    int r, l;
    logic [41:0] area;
    if (!err) begin
      case (op_t'(b.op)) inside
        OP_LEAF: begin
          if (nleaf >= MAX_MODULES || depth >= MAX_MODULES) err = 1;
          else begin
            lf_id[nleaf] = b.module_id;
            lf_x[nleaf] = '0;
            lf_y[nleaf] = '0;
            cl_first[depth] = nleaf;
            cl_last[depth] = nleaf;
            cl_w[depth] = dim(b.module_width);
            cl_h[depth] = dim(b.module_height);
            depth++;
            nleaf++;
          end
        end
        OP_HCUT, OP_VCUT: begin
          if (depth < 2) err = 1;
          else begin
            r = depth - 1;
            l = depth - 2;
            for (int j = cl_first[r]; j <= cl_last[r]; j++) begin
              if (b.op == OP_HCUT) lf_y[j] = add_sat(lf_y[j], cl_h[l]);
              else lf_x[j] = add_sat(lf_x[j], cl_w[l]);
            end
            if (b.op == OP_HCUT) begin
              cl_w[l] = (cl_w[l] > cl_w[r]) ? cl_w[l] : cl_w[r];
              cl_h[l] = add_sat(cl_h[l], cl_h[r]);
            end else begin
              cl_w[l] = add_sat(cl_w[l], cl_w[r]);
              cl_h[l] = (cl_h[l] > cl_h[r]) ? cl_h[l] : cl_h[r];
            end
            cl_last[l] = cl_last[r];
            depth = l + 1;
          end
        end
        default: err = 1;
      endcase
    end
    if (!b.final_item) return;
    if (err || depth != 1) begin
      o = '0;
      o.invalid = 1;
      o.last_result = 1;
      placements_q.push_back(o);
    end else begin
      area = 42'(cl_w[0]) * 42'(cl_h[0]);
      for (int k = 0; k < nleaf; k++) begin
        o.leaf_ident = lf_id[k];
        o.pos_x = lf_x[k];
        o.pos_y = lf_y[k];
        o.total_area = area;
        o.invalid = 0;
        o.last_result = (k + 1 == nleaf);
        placements_q.push_back(o);
      end
    end
    depth = 0;
    nleaf = 0;
    err = 0;
  endtask

  assign pending = placements_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      fail_count = 0;
      depth = 0;
      nleaf = 0;
      err = 0;
      placements_q.delete();
    end else begin
      if (out_valid) begin
        if (placements_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_beat);
          fail_count++;
        end else begin
          want = placements_q.pop_front();
          if (out_beat !== want) begin
            $display("%0t: mismatch expected id=%0d x=%0d y=%0d area=%0d inv=%b last=%b",
                     $time, want.leaf_ident, want.pos_x, want.pos_y, want.total_area,
                     want.invalid, want.last_result);
            $display("%0t:            actual id=%0d x=%0d y=%0d area=%0d inv=%b last=%b",
                     $time, out_beat.leaf_ident, out_beat.pos_x, out_beat.pos_y,
                     out_beat.total_area, out_beat.invalid, out_beat.last_result);
            fail_count++;
          end
        end
      end
      if (start && !busy) place_item(in_beat);
    end
  end
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the slicing floorplan packer
// Directed and random postfix expressions under varied sender idling.
// ----------------------------------------------------------------------------
module tb_top;
  import sfp_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;
  int        fail_count;
  int        pending;
  int        idle_pct = 0;   // sender idle chance, percent

  always #5 clk = ~clk;

  slicing_floorplan_packer_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  sfp_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat),
    .fail_count(fail_count), .pending(pending)
  );

  // Hold one beat until taken; random idle gaps come before start rises.
  task automatic send_beat(op_t op, logic [7:0] id, logic [15:0] w, logic [15:0] h,
                           logic fin);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_beat.op = op;
    in_beat.module_id = id;
    in_beat.module_width = w;
    in_beat.module_height = h;
    in_beat.final_item = fin;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(3))
      0: return 16'(($urandom_range(1) ? 16'hFFFF : 16'h0000));
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic leaf(logic fin = 0);
    send_beat(OP_LEAF, 8'($urandom), rand_dim(), rand_dim(), fin);
  endtask

  // Random well-formed expression of n leaves: keep a depth count and
  // cut whenever two clusters are available and a coin says so.
  task automatic good_expr(int n);
    int d, placed;
    d = 0;
    placed = 0;
    while (placed < n || d > 1) begin
      if (placed < n && (d < 2 || $urandom_range(1))) begin
        placed++;
        d++;
        send_beat(OP_LEAF, 8'($urandom), rand_dim(), rand_dim(), (placed == 1 && n == 1));
      end else begin
        d--;
        send_beat($urandom_range(1) ? OP_HCUT : OP_VCUT, 8'($urandom), 16'($urandom),
                  16'($urandom), d == 1 && placed == n);
      end
    end
  endtask

  // Random noise: any op, including the unused code, ended by a final beat.
  task automatic noisy_expr(int n);
    for (int i = 0; i < n; i++)
      send_beat(op_t'($urandom_range(3)), 8'($urandom), 16'($urandom), 16'($urandom),
                i == n - 1);
  endtask

  task automatic wait_drain();
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: single leaf with extremes, both cuts, underflow, bad op,
    // depth not one, capacity overflow.
    send_beat(OP_LEAF, 8'hFF, 16'hFFFF, 16'hFFFF, 1);
    send_beat(OP_LEAF, 8'h00, 16'h0000, 16'h0000, 0);
    send_beat(OP_LEAF, 8'hA5, 16'h1234, 16'h0FED, 0);
    send_beat(OP_HCUT, 8'h00, 16'h0, 16'h0, 0);
    send_beat(OP_LEAF, 8'h5A, 16'h00FF, 16'hFF00, 0);
    send_beat(OP_VCUT, 8'hFF, 16'hFFFF, 16'hFFFF, 1);
    send_beat(OP_HCUT, 8'h01, 16'h1, 16'h1, 1);       // underflow
    send_beat(OP_LEAF, 8'h02, 16'h2, 16'h2, 0);
    send_beat(OP_BAD,  8'h03, 16'h3, 16'h3, 0);      // unused op code
    send_beat(OP_LEAF, 8'h04, 16'h4, 16'h4, 1);
    send_beat(OP_LEAF, 8'h05, 16'h5, 16'h5, 0);
    send_beat(OP_LEAF, 8'h06, 16'h6, 16'h6, 1);      // depth two at end
    for (int i = 0; i < 33; i++) leaf(i == 32);      // capacity overflow
    // Deep chain of cuts building large coordinates.
    for (int i = 0; i < 32; i++)
      send_beat(OP_LEAF, 8'(i), 16'hFFFF, 16'hFFFF, 0);
    for (int i = 0; i < 31; i++)
      send_beat(i[0] ? OP_HCUT : OP_VCUT, 8'h0, 16'h0, 16'h0, i == 30);
    wait_drain();   // sender holds off until everything is back

    // phases: no idling, sender idle, receiver stall (not applicable), both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 86 : (ph == 3) ? 31 : 0;
      for (int e = 0; e < 4; e++) begin
        if ($urandom_range(4) == 0) noisy_expr($urandom_range(1, 5));
        else good_expr(($urandom_range(9) == 0) ? 32 : $urandom_range(1, 6));
      end
    end
    wait_drain();

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
